FILE: rtl/console_line_editor_with_login_assert.svh
// assertion macros used by the console line editor checker
`ifndef CONSOLE_LINE_EDITOR_WITH_LOGIN_ASSERT_SVH
`define CONSOLE_LINE_EDITOR_WITH_LOGIN_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define CLED_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cled assertion failed");

// next-cycle implication, disabled while reset is asserted
`define CLED_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cled assertion failed");

`endif

FILE: rtl/cled_pkg.sv
// types and constants of the console line editor
`default_nettype none

package cled_pkg;

	// queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_LOGIN_REQUIRED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT   = 1'd1;
	localparam logic [31:0] IDLE_TIMEOUT_RESET = 32'd60000;

	// request types
	localparam logic [1:0] REQ_BYTE    = 2'd0;
	localparam logic [1:0] REQ_TICK    = 2'd1;
	localparam logic [1:0] REQ_VERDICT = 2'd2;

	// characters
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_DEL      = 8'h7F;
	localparam logic [7:0] CH_LOW      = 8'h1F;
	localparam logic [7:0] CH_PRINT_LO = CH_LOW + 8'd1;
	localparam logic [7:0] CH_PRINT_HI = CH_DEL - 8'd1;

	// classified operations
	typedef logic [2:0] op_t;
	localparam op_t OP_ACT   = 3'd0;
	localparam op_t OP_CR    = 3'd1;
	localparam op_t OP_DEL   = 3'd2;
	localparam op_t OP_PRINT = 3'd3;
	localparam op_t OP_TICK  = 3'd4;
	localparam op_t OP_ACC   = 3'd5;
	localparam op_t OP_REJ   = 3'd6;

	// result kinds
	typedef logic [3:0] kind_t;
	localparam kind_t KIND_ECHO       = 4'd0;
	localparam kind_t KIND_CMD        = 4'd1;
	localparam kind_t KIND_PWD        = 4'd2;
	localparam kind_t KIND_EMPTY_PWD  = 4'd3;
	localparam kind_t KIND_ACCEPT     = 4'd4;
	localparam kind_t KIND_REJECT     = 4'd5;
	localparam kind_t KIND_LOGOUT_TO  = 4'd6;
	localparam kind_t KIND_INPUT_TO   = 4'd7;
	localparam kind_t KIND_PWD_TO     = 4'd8;

	// queue entry
	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} entry_t;

	// configuration registers
	typedef struct packed {
		logic        login_required;
		logic [31:0] idle_timeout_ticks;
	} cfg_t;

endpackage

`default_nettype wire

FILE: rtl/console_line_editor_with_login.sv
// Console line editor with login: top level, configuration registers and wiring.
// A request goes through the queue to the output register. A carriage return gives CR, LF,
// then each line character by a registered read and then output, or a notice in their
// place when no login is required or the password line is empty. Throughput: one request
// per cycle unless the queue is full or the output stalls, except carriage returns. Reset
// (arst_n low) clears the line, login, pending verdict, idle count and resets the registers.
`default_nettype none

module console_line_editor_with_login #(
	parameter int LINE_CAPACITY = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     req_type,
	input  wire logic [7:0]                     rx_byte,
	input  wire logic                           verdict_accept,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [3:0]                          out_kind,
	output logic [7:0]                          out_byte,
	output logic                                out_last,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [cled_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                    cfg_data
);
	import cled_pkg::*;

	cfg_t   cfg_q;
	logic   q_valid;
	entry_t q_entry;
	logic   q_pop;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.login_required     <= 1'b0;
			cfg_q.idle_timeout_ticks <= IDLE_TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LOGIN_REQUIRED: cfg_q.login_required     <= cfg_data[0];
				REG_IDLE_TIMEOUT:   cfg_q.idle_timeout_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	// request classification and queue
	cled_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.rx_byte        (rx_byte),
		.verdict_accept (verdict_accept),
		.q_valid        (q_valid),
		.q_entry        (q_entry),
		.q_pop          (q_pop)
	);

	// execution and result sequencing
	cled_back #(
		.LINE_CAPACITY (LINE_CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_kind  (out_kind),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule

`default_nettype wire

FILE: rtl/cled_front.sv
// front end: classifies requests and queues them for the back end
`default_nettype none

module cled_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic [1:0]      req_type,
	input  wire logic [7:0]      rx_byte,
	input  wire logic            verdict_accept,
	output logic                 q_valid,
	output cled_pkg::entry_t     q_entry,
	input  wire logic            q_pop
);
	import cled_pkg::*;

	entry_t               entry_q [QDEPTH];
	logic [QPTR_W-1:0]    wr_ptr_q;
	logic [QPTR_W-1:0]    rd_ptr_q;
	logic [QPTR_W:0]      count_q;
	entry_t               cls;
	logic                 cls_keep;
	logic                 push;

	// classify the incoming request
	always_comb begin
		cls.op   = OP_ACT;
		cls.data = rx_byte;
		cls_keep = 1'b1;
		case (req_type)
			REQ_BYTE: begin
				if (rx_byte == CH_CR)
					cls.op = OP_CR;
				else if (rx_byte == CH_DEL)
					cls.op = OP_DEL;
				else if (rx_byte inside {[CH_PRINT_LO:CH_PRINT_HI]})
					cls.op = OP_PRINT;
				else
					cls.op = OP_ACT;
			end
			REQ_TICK:    cls.op = OP_TICK;
			REQ_VERDICT: cls.op = verdict_accept ? OP_ACC : OP_REJ;
			default:     cls_keep = 1'b0;
		endcase
	end

	assign in_stall = (count_q == (QPTR_W+1)'(QDEPTH));
	assign push     = in_valid && !in_stall && cls_keep;
	assign q_valid  = (count_q != '0);
	assign q_entry  = entry_q[rd_ptr_q];

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (q_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !q_pop)
				count_q <= count_q + (QPTR_W+1)'(1);
			else if (!push && q_pop)
				count_q <= count_q - (QPTR_W+1)'(1);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= cls;
	end

endmodule

`default_nettype wire

FILE: rtl/cled_back.sv
// back end: line state, login state, idle timer and result sequencer
`default_nettype none

module cled_back #(
	parameter int LINE_CAPACITY = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	input  wire cled_pkg::entry_t  q_entry,
	output logic                   q_pop,
	input  wire cled_pkg::cfg_t    cfg,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output cled_pkg::kind_t        out_kind,
	output logic [7:0]             out_byte,
	output logic                   out_last
);
	import cled_pkg::*;

	localparam int LEN_W = $clog2(LINE_CAPACITY);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LF   = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_DUMP = 3'd3;
	localparam logic [2:0] ST_NOTE = 3'd4;

	// what follows a carriage return
	localparam logic [1:0] MODE_CMD  = 2'd0;
	localparam logic [1:0] MODE_PWD  = 2'd1;
	localparam logic [1:0] MODE_OPEN = 2'd2;

	logic [7:0]       line_mem [LINE_CAPACITY];
	logic [7:0]       rd_data_q;

	logic [2:0]       state_q, state_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic             logged_q, logged_d;
	logic             pend_q, pend_d;
	logic [31:0]      idle_q, idle_d;
	logic [1:0]       mode_q, mode_d;
	logic [LEN_W-1:0] dump_len_q, dump_len_d;
	logic [LEN_W-1:0] rd_idx_q, rd_idx_d;

	logic             out_valid_q;
	kind_t            out_kind_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;

	logic             out_free;
	logic             wr_en;
	logic             emit_valid;
	kind_t            emit_kind;
	logic [7:0]       emit_byte;
	logic             emit_last;
	logic [31:0]      idle_inc;
	logic             has_room;
	logic             dump_end;

	assign out_free = !out_valid_q || !out_stall;
	assign idle_inc = (idle_q == '1) ? idle_q : idle_q + 32'd1;
	assign has_room = ((LEN_W+1)'(len_q) + (LEN_W+1)'(1)) < (LEN_W+1)'(LINE_CAPACITY);
	assign dump_end = ((LEN_W+1)'(rd_idx_q) + (LEN_W+1)'(1)) == (LEN_W+1)'(dump_len_q);

	// request execution and result sequencing
	always_comb begin
		state_d    = state_q;
		len_d      = len_q;
		logged_d   = logged_q;
		pend_d     = pend_q;
		idle_d     = idle_q;
		mode_d     = mode_q;
		dump_len_d = dump_len_q;
		rd_idx_d   = rd_idx_q;
		wr_en      = 1'b0;
		q_pop      = 1'b0;
		emit_valid = 1'b0;
		emit_kind  = KIND_ECHO;
		emit_byte  = '0;
		emit_last  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					case (q_entry.op)
						OP_ACT: idle_d = '0;
						OP_CR: begin
							idle_d = '0;
							if (!pend_q) begin
								emit_valid = 1'b1;
								emit_byte  = CH_CR;
								dump_len_d = len_q;
								len_d      = '0;
								state_d    = ST_LF;
								if (logged_q) begin
									mode_d = MODE_CMD;
								end else if (cfg.login_required) begin
									mode_d = MODE_PWD;
									pend_d = 1'b1;
								end else begin
									mode_d   = MODE_OPEN;
									logged_d = 1'b1;
								end
							end
						end
						OP_DEL: begin
							idle_d = '0;
							if (!pend_q && len_q != '0) begin
								len_d      = len_q - LEN_W'(1);
								emit_valid = logged_q;
								emit_byte  = CH_DEL;
								emit_last  = 1'b1;
							end
						end
						OP_PRINT: begin
							idle_d = '0;
							if (!pend_q && has_room) begin
								wr_en      = 1'b1;
								len_d      = len_q + LEN_W'(1);
								emit_valid = logged_q;
								emit_byte  = q_entry.data;
								emit_last  = 1'b1;
							end
						end
						OP_TICK: begin
							idle_d    = idle_inc;
							emit_last = 1'b1;
							if (idle_inc > cfg.idle_timeout_ticks) begin
								if (logged_q && cfg.login_required) begin
									len_d      = '0;
									logged_d   = 1'b0;
									emit_valid = 1'b1;
									emit_kind  = KIND_LOGOUT_TO;
								end else if (logged_q && len_q != '0) begin
									len_d      = '0;
									emit_valid = 1'b1;
									emit_kind  = KIND_INPUT_TO;
								end else if (!logged_q && len_q != '0) begin
									len_d      = '0;
									emit_valid = 1'b1;
									emit_kind  = KIND_PWD_TO;
								end
							end
						end
						OP_ACC, OP_REJ: begin
							if (pend_q) begin
								pend_d     = 1'b0;
								emit_valid = 1'b1;
								emit_last  = 1'b1;
								if (q_entry.op == OP_ACC) begin
									logged_d  = 1'b1;
									emit_kind = KIND_ACCEPT;
								end else begin
									emit_kind = KIND_REJECT;
								end
							end
						end
						default: ;
					endcase
				end
			end
			ST_LF: begin
				if (out_free) begin
					emit_valid = 1'b1;
					emit_byte  = CH_LF;
					rd_idx_d   = '0;
					if (dump_len_q != '0 && mode_q != MODE_OPEN) begin
						state_d = ST_RD;
					end else if (mode_q == MODE_CMD) begin
						emit_last = 1'b1;
						state_d   = ST_IDLE;
					end else begin
						state_d = ST_NOTE;
					end
				end
			end
			ST_RD: state_d = ST_DUMP;
			ST_DUMP: begin
				if (out_free) begin
					emit_valid = 1'b1;
					emit_kind  = (mode_q == MODE_CMD) ? KIND_CMD : KIND_PWD;
					emit_byte  = rd_data_q;
					emit_last  = dump_end;
					rd_idx_d   = rd_idx_q + LEN_W'(1);
					state_d    = dump_end ? ST_IDLE : ST_RD;
				end
			end
			ST_NOTE: begin
				if (out_free) begin
					emit_valid = 1'b1;
					emit_kind  = (mode_q == MODE_PWD) ? KIND_EMPTY_PWD : KIND_ACCEPT;
					emit_last  = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control and line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			logged_q    <= 1'b0;
			pend_q      <= 1'b0;
			idle_q      <= '0;
			mode_q      <= MODE_CMD;
			dump_len_q  <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			len_q      <= len_d;
			logged_q   <= logged_d;
			pend_q     <= pend_d;
			idle_q     <= idle_d;
			mode_q     <= mode_d;
			dump_len_q <= dump_len_d;
			rd_idx_q   <= rd_idx_d;
			if (out_free)
				out_valid_q <= emit_valid;
		end
	end

	// line memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			line_mem[len_q] <= q_entry.data;
		rd_data_q <= line_mem[rd_idx_q];
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit_valid) begin
			out_kind_q <= emit_kind;
			out_byte_q <= emit_byte;
			out_last_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

FILE: rtl/cled_checker.sv
// port-level checker for the console line editor, bound to the top level
`default_nettype none

`include "console_line_editor_with_login_assert.svh"

module cled_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [3:0] out_kind,
	input wire logic [7:0] out_byte,
	input wire logic       out_last
);
	import cled_pkg::*;

	logic is_notice;

	assign is_notice = out_kind inside {[KIND_EMPTY_PWD:KIND_PWD_TO]};

	// a stalled request stays offered
	`CLED_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// a stalled request keeps its payload
	`CLED_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(out_kind) && $stable(out_byte) && $stable(out_last))

	// notices carry no byte
	`CLED_ASSERT_IMP(a_notice_zero, clk, arst_n, out_valid && is_notice, out_byte == 8'd0)

	// a notice always ends the sequence of its request
	`CLED_ASSERT_IMP(a_notice_last, clk, arst_n, out_valid && is_notice, out_last)

endmodule

bind console_line_editor_with_login cled_checker u_cled_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_kind  (out_kind),
	.out_byte  (out_byte),
	.out_last  (out_last)
);

`default_nettype wire
